### design/mtc_pkg.sv
// ----------------------------------------------------------------------------
// mtc_pkg: shared types and codes of the Markov transition counter
// Command codes, register indexes, internal op codes and back-end states.
// ----------------------------------------------------------------------------
package mtc_pkg;

    // command field
    localparam int CMD_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR      = 2'd0,
        CMD_SYMBOL     = 2'd1,
        CMD_READ_TRANS = 2'd2,
        CMD_READ_INIT  = 2'd3
    } t_cmd;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;
    localparam int SC_W       = 4;
    localparam int MO_W       = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STATE_COUNT      = 2'd0,
        CFG_MODEL_ORDER      = 2'd1,
        CFG_COUNT_FROM_START = 2'd2
    } t_cfg_idx;

    localparam logic [SC_W-1:0] SC_RESET  = 4'd2;
    localparam logic [MO_W-1:0] MO_RESET  = 2'd1;
    localparam logic            CFS_RESET = 1'b1;

    // work handed from front end to back end
    typedef enum logic [2:0] {
        OP_CLEAR      = 3'd0,
        OP_BUMP_TRANS = 3'd1,
        OP_BUMP_INIT  = 3'd2,
        OP_READ_TRANS = 3'd3,
        OP_READ_INIT  = 3'd4
    } t_op_kind;

    typedef struct packed {
        t_op_kind kind;
        logic     in_range;
    } t_op_ctl;

    // back-end sequencer
    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_WAIT  = 3'b010,
        S_SWEEP = 3'b100
    } t_back_state;

endpackage

### design/mtc_fifo.sv
// ----------------------------------------------------------------------------
// mtc_fifo: small register queue
// Fall-through read of the oldest entry; push and pop in the same cycle allowed.
// ----------------------------------------------------------------------------
module mtc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_do_push;
    logic             w_do_pop;

    // status
    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_data    = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= PTR_W'(r_wr_ptr + 1'b1);
            end
            if (w_do_pop) begin
                r_rd_ptr <= PTR_W'(r_rd_ptr + 1'b1);
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= CNT_W'(r_count + 1'b1);
            end else if (w_do_pop && !w_do_push) begin
                r_count <= CNT_W'(r_count - 1'b1);
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

### design/mtc_front.sv
// ----------------------------------------------------------------------------
// mtc_front: command intake and classification
// Holds configuration and the context history, computes the table address of
// each symbol and queues one op per item that touches the tables.
// ----------------------------------------------------------------------------
module mtc_front
    import mtc_pkg::*;
#(
    parameter int MAX_STATES = 8,
    parameter int MAX_ORDER  = 3
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]                   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]                  i_cfg_data,
    input  logic                                   i_push,
    output logic                                   o_full,
    input  logic [CMD_W-1:0]                       i_cmd,
    input  logic [$clog2(MAX_STATES)-1:0]          i_state_value,
    input  logic                                   i_seq_start,
    input  logic [$clog2(MAX_STATES)*MAX_ORDER-1:0] i_read_row,
    input  logic [$clog2(MAX_STATES)-1:0]          i_read_col,
    input  logic                                   i_init_busy,
    input  logic                                   i_q_full,
    output logic                                   o_q_push,
    output t_op_ctl                                o_q_ctl,
    output logic [$clog2(MAX_STATES)*(MAX_ORDER+1)-1:0] o_q_addr
);

    localparam int SYM_W  = $clog2(MAX_STATES);
    localparam int ROW_W  = SYM_W * MAX_ORDER;
    localparam int ADDR_W = ROW_W + SYM_W;
    localparam int POW_W  = ROW_W + 1;
    localparam int NUM_W  = $clog2(MAX_STATES + 1);
    localparam int ORD_W  = $clog2(MAX_ORDER + 1);

    logic [SC_W-1:0]  r_state_count;
    logic [MO_W-1:0]  r_model_order;
    logic             r_count_from_start;
    logic [ORD_W-1:0] r_settle;
    logic [SYM_W-1:0] r_hist [0:MAX_ORDER-1];
    logic [ORD_W-1:0] r_seen;
    logic [POW_W-1:0] r_pow  [1:MAX_ORDER];

    logic [NUM_W-1:0] w_n;
    logic [ORD_W-1:0] w_o;
    logic [POW_W-1:0] w_pow    [0:MAX_ORDER];
    logic [POW_W-1:0] w_weight [0:MAX_ORDER-1];
    logic [POW_W-1:0] w_rows;
    logic [POW_W-1:0] w_row;
    logic             w_accept;
    logic             w_sym_ok;
    logic             w_counting;

    // effective state count and order
    always_comb begin
        if (r_state_count < 4'd2) begin
            w_n = NUM_W'(2);
        end else if (int'(r_state_count) > MAX_STATES) begin
            w_n = NUM_W'(MAX_STATES);
        end else begin
            w_n = NUM_W'(r_state_count);
        end
        if (r_model_order == '0) begin
            w_o = ORD_W'(1);
        end else if (int'(r_model_order) > MAX_ORDER) begin
            w_o = ORD_W'(MAX_ORDER);
        end else begin
            w_o = ORD_W'(r_model_order);
        end
    end

    // powers of the state count, one multiply per register
    always_ff @(posedge i_clk) begin
        r_pow[1] <= POW_W'(w_n);
        for (int e = 2; e <= MAX_ORDER; e++) begin
            r_pow[e] <= POW_W'(r_pow[e-1] * POW_W'(w_n));
        end
    end

    // place weights of the history and number of rows in use
    always_comb begin
        w_pow[0] = POW_W'(1);
        for (int e = 1; e <= MAX_ORDER; e++) begin
            w_pow[e] = r_pow[e];
        end
        w_rows = '0;
        for (int e = 1; e <= MAX_ORDER; e++) begin
            if (int'(w_o) == e) begin
                w_rows = w_pow[e];
            end
        end
        for (int k = 0; k < MAX_ORDER; k++) begin
            w_weight[k] = '0;
            for (int e = 0; e < MAX_ORDER; e++) begin
                if (int'(w_o) == k + 1 + e) begin
                    w_weight[k] = w_pow[e];
                end
            end
        end
    end

    // context row of the current history
    always_comb begin
        w_row = '0;
        for (int k = 0; k < MAX_ORDER; k++) begin
            w_row = POW_W'(w_row + POW_W'(POW_W'(r_hist[k]) * w_weight[k]));
        end
    end

    // intake
    assign o_full     = i_q_full || (r_settle != '0) || i_init_busy;
    assign w_accept   = i_push && !o_full;
    assign w_sym_ok   = int'(i_state_value) < int'(w_n);
    assign w_counting = r_count_from_start || (int'(r_seen) >= int'(w_o));

    // classification into back-end ops
    always_comb begin
        o_q_push         = 1'b0;
        o_q_ctl.kind     = OP_CLEAR;
        o_q_ctl.in_range = 1'b0;
        o_q_addr         = '0;
        case (t_cmd'(i_cmd))
            CMD_CLEAR: begin
                o_q_push = w_accept;
            end
            CMD_SYMBOL: begin
                if (i_seq_start) begin
                    o_q_push     = w_accept && w_sym_ok;
                    o_q_ctl.kind = OP_BUMP_INIT;
                    o_q_addr     = ADDR_W'(i_state_value);
                end else begin
                    o_q_push     = w_accept && w_sym_ok && w_counting && (w_row < w_rows);
                    o_q_ctl.kind = OP_BUMP_TRANS;
                    o_q_addr     = {w_row[ROW_W-1:0], i_state_value};
                end
                o_q_ctl.in_range = 1'b1;
            end
            CMD_READ_TRANS: begin
                o_q_push         = w_accept;
                o_q_ctl.kind     = OP_READ_TRANS;
                o_q_ctl.in_range = (POW_W'(i_read_row) < w_rows)
                                   && (int'(i_read_col) < int'(w_n));
                o_q_addr         = {i_read_row, i_read_col};
            end
            CMD_READ_INIT: begin
                o_q_push         = w_accept;
                o_q_ctl.kind     = OP_READ_INIT;
                o_q_ctl.in_range = int'(i_read_col) < int'(w_n);
                o_q_addr         = ADDR_W'(i_read_col);
            end
            default: begin
                o_q_push = 1'b0;
            end
        endcase
    end

    // configuration, settle timer, history and sequence position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state_count      <= SC_RESET;
            r_model_order      <= MO_RESET;
            r_count_from_start <= CFS_RESET;
            r_settle           <= ORD_W'(MAX_ORDER);
            r_seen             <= '0;
            for (int k = 0; k < MAX_ORDER; k++) begin
                r_hist[k] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_settle <= ORD_W'(MAX_ORDER);
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_STATE_COUNT:      r_state_count      <= i_cfg_data[SC_W-1:0];
                    CFG_MODEL_ORDER:      r_model_order      <= i_cfg_data[MO_W-1:0];
                    CFG_COUNT_FROM_START: r_count_from_start <= i_cfg_data[0];
                    default: ;
                endcase
            end else if (r_settle != '0) begin
                r_settle <= ORD_W'(r_settle - 1'b1);
            end
            if (w_accept && (t_cmd'(i_cmd) == CMD_SYMBOL) && w_sym_ok) begin
                if (i_seq_start) begin
                    // new sequence: history filled with its first state
                    for (int k = 0; k < MAX_ORDER; k++) begin
                        r_hist[k] <= i_state_value;
                    end
                    r_seen <= ORD_W'(1);
                end else begin
                    for (int k = 1; k < MAX_ORDER; k++) begin
                        r_hist[k] <= r_hist[k-1];
                    end
                    r_hist[0] <= i_state_value;
                    if (int'(r_seen) < MAX_ORDER) begin
                        r_seen <= ORD_W'(r_seen + 1'b1);
                    end
                end
            end
        end
    end

endmodule

### design/mtc_back.sv
// ----------------------------------------------------------------------------
// mtc_back: table engine
// Executes queued ops against the transition memory and the initial counts,
// sweeps the memory on clear and after reset, and buffers read results.
// ----------------------------------------------------------------------------
module mtc_back
    import mtc_pkg::*;
#(
    parameter int MAX_STATES = 8,
    parameter int MAX_ORDER  = 3,
    parameter int COUNT_BITS = 32
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_op_valid,
    input  t_op_ctl                                     i_op_ctl,
    input  logic [$clog2(MAX_STATES)*(MAX_ORDER+1)-1:0] i_op_addr,
    output logic                                        o_op_pop,
    output logic                                        o_init_busy,
    output logic                                        o_empty,
    input  logic                                        i_pop,
    output logic [COUNT_BITS-1:0]                       o_count_value
);

    localparam int SYM_W      = $clog2(MAX_STATES);
    localparam int ADDR_W     = SYM_W * (MAX_ORDER + 1);
    localparam int MEM_DEPTH  = 1 << ADDR_W;
    localparam int INIT_DEPTH = 1 << SYM_W;
    localparam int RES_DEPTH  = 2;

    t_back_state           r_state;
    t_back_state           n_state;
    logic [ADDR_W-1:0]     r_sweep_addr;
    logic                  r_init_pass;
    logic [ADDR_W-1:0]     r_addr;
    logic                  r_bump;
    logic                  r_in_range;
    logic [COUNT_BITS-1:0] r_rd_data;
    logic [COUNT_BITS-1:0] r_init [0:INIT_DEPTH-1];
    logic [COUNT_BITS-1:0] r_mem  [0:MEM_DEPTH-1];

    logic [SYM_W-1:0]      w_col;
    logic [COUNT_BITS-1:0] w_init_val;
    logic                  w_issue;
    logic                  w_init_bump;
    logic                  w_init_clr;
    logic                  w_mem_we;
    logic [ADDR_W-1:0]     w_mem_waddr;
    logic [COUNT_BITS-1:0] w_mem_wdata;
    logic                  w_res_push;
    logic [COUNT_BITS-1:0] w_res_data;
    logic                  w_res_full;
    logic                  w_sweep_last;

    assign w_col        = i_op_addr[SYM_W-1:0];
    assign w_init_val   = r_init[w_col];
    assign w_sweep_last = &r_sweep_addr;
    assign o_init_busy  = r_init_pass;

    // sequencer
    always_comb begin
        n_state     = r_state;
        o_op_pop    = 1'b0;
        w_issue     = 1'b0;
        w_init_bump = 1'b0;
        w_init_clr  = 1'b0;
        w_mem_we    = 1'b0;
        w_mem_waddr = r_addr;
        w_mem_wdata = '0;
        w_res_push  = 1'b0;
        w_res_data  = '0;
        case (r_state)
            S_IDLE: begin
                if (i_op_valid) begin
                    case (i_op_ctl.kind)
                        OP_CLEAR: begin
                            o_op_pop   = 1'b1;
                            w_init_clr = 1'b1;
                            n_state    = S_SWEEP;
                        end
                        OP_BUMP_INIT: begin
                            o_op_pop    = 1'b1;
                            w_init_bump = 1'b1;
                        end
                        OP_READ_INIT: begin
                            if (!w_res_full) begin
                                o_op_pop   = 1'b1;
                                w_res_push = 1'b1;
                                w_res_data = i_op_ctl.in_range ? w_init_val : '0;
                            end
                        end
                        OP_BUMP_TRANS: begin
                            o_op_pop = 1'b1;
                            w_issue  = 1'b1;
                            n_state  = S_WAIT;
                        end
                        OP_READ_TRANS: begin
                            if (!w_res_full) begin
                                o_op_pop = 1'b1;
                                w_issue  = 1'b1;
                                n_state  = S_WAIT;
                            end
                        end
                        default: begin
                            o_op_pop = 1'b1;
                        end
                    endcase
                end
            end
            S_WAIT: begin
                // read data of the issued address is now registered
                if (r_bump) begin
                    w_mem_we    = 1'b1;
                    w_mem_wdata = (&r_rd_data) ? r_rd_data : COUNT_BITS'(r_rd_data + 1'b1);
                end else begin
                    w_res_push = 1'b1;
                    w_res_data = r_in_range ? r_rd_data : '0;
                end
                n_state = S_IDLE;
            end
            S_SWEEP: begin
                w_mem_we    = 1'b1;
                w_mem_waddr = r_sweep_addr;
                if (w_sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state and initial counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_SWEEP;
            r_sweep_addr <= '0;
            r_init_pass  <= 1'b1;
            for (int i = 0; i < INIT_DEPTH; i++) begin
                r_init[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (r_state == S_SWEEP) begin
                r_sweep_addr <= ADDR_W'(r_sweep_addr + 1'b1);
                if (w_sweep_last) begin
                    r_init_pass <= 1'b0;
                end
            end
            if (w_init_clr) begin
                for (int i = 0; i < INIT_DEPTH; i++) begin
                    r_init[i] <= '0;
                end
            end else if (w_init_bump && !(&w_init_val)) begin
                r_init[w_col] <= COUNT_BITS'(w_init_val + 1'b1);
            end
        end
    end

    // op held across the read-modify-write
    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_addr     <= i_op_addr;
            r_bump     <= (i_op_ctl.kind == OP_BUMP_TRANS);
            r_in_range <= i_op_ctl.in_range;
        end
    end

    // transition count memory
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_waddr] <= w_mem_wdata;
        end
        r_rd_data <= r_mem[i_op_addr];
    end

    // result buffer
    mtc_fifo #(
        .WIDTH (COUNT_BITS),
        .DEPTH (RES_DEPTH)
    ) u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res_data),
        .o_full  (w_res_full),
        .i_pop   (i_pop),
        .o_data  (o_count_value),
        .o_empty (o_empty)
    );

    // checks
    a_res_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_push |-> !w_res_full)
        else $error("result pushed into a full buffer");

    a_issue_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_issue |=> (r_state == S_WAIT))
        else $error("memory access issued without a wait cycle");

    a_wait_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WAIT) |-> (r_addr == $past(i_op_addr)))
        else $error("write-back address differs from read address");

    a_sweep_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SWEEP) && w_sweep_last) |=> (r_state == S_IDLE))
        else $error("clear sweep did not end after last entry");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_op_pop |-> ((r_state == S_IDLE) && i_op_valid))
        else $error("op taken outside idle or from an empty queue");

endmodule

### design/markov_transition_counter_core.sv
// ----------------------------------------------------------------------------
// markov_transition_counter_core: order-k Markov transition counter
// Counts initial states and context-to-state transitions of a symbol stream.
// ----------------------------------------------------------------------------
// Usage
//   Commands enter through a queue-like port: an item is taken on a clock
//   edge with push high and full low. Read commands (transition count,
//   initial count) each produce one result, shown on o_count_value while
//   empty is low and taken on an edge with pop high. Clear and symbol
//   commands produce no result.
//   The front end classifies a command in its accept cycle and hands an op
//   to a 4-entry queue; the back end runs ops one at a time. A transition
//   bump or read reads the count memory on issue, then in the wait state a
//   bump writes the count back and a read buffers it. An initial-count op
//   is done in the idle state; an ignored symbol costs nothing in the back
//   end. A clear walks all 2^(SYM_W*(MAX_ORDER+1)) count memory entries,
//   4096 at the default sizes, one entry a cycle. A read passes through the
//   op queue and then the result buffer, a transition count also through
//   the memory read register. After reset the same sweep runs once while
//   full stays high; full also stays high after a configuration write until
//   the settle timer runs out. A stalled receiver fills the 2-entry result
//   buffer, then the op queue, then full rises; nothing is dropped.
// ----------------------------------------------------------------------------
module markov_transition_counter_core
    import mtc_pkg::*;
#(
    parameter int MAX_STATES = 8,
    parameter int MAX_ORDER  = 3,
    parameter int COUNT_BITS = 32
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]                    i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]                   i_cfg_data,
    input  logic                                    push,
    output logic                                    full,
    input  logic [CMD_W-1:0]                        i_cmd,
    input  logic [$clog2(MAX_STATES)-1:0]           i_state_value,
    input  logic                                    i_seq_start,
    input  logic [$clog2(MAX_STATES)*MAX_ORDER-1:0] i_read_row,
    input  logic [$clog2(MAX_STATES)-1:0]           i_read_col,
    output logic                                    empty,
    input  logic                                    pop,
    output logic [COUNT_BITS-1:0]                   o_count_value
);

    localparam int SYM_W   = $clog2(MAX_STATES);
    localparam int ADDR_W  = SYM_W * (MAX_ORDER + 1);
    localparam int CTL_W   = $bits(t_op_ctl);
    localparam int Q_W     = CTL_W + ADDR_W;
    localparam int Q_DEPTH = 4;

    logic              w_q_push;
    t_op_ctl           w_q_ctl;
    logic [ADDR_W-1:0] w_q_addr;
    logic              w_q_full;
    logic              w_q_pop;
    logic              w_q_empty;
    logic [Q_W-1:0]    w_q_rdata;
    logic              w_init_busy;

    // command intake
    mtc_front #(
        .MAX_STATES (MAX_STATES),
        .MAX_ORDER  (MAX_ORDER)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_push        (push),
        .o_full        (full),
        .i_cmd         (i_cmd),
        .i_state_value (i_state_value),
        .i_seq_start   (i_seq_start),
        .i_read_row    (i_read_row),
        .i_read_col    (i_read_col),
        .i_init_busy   (w_init_busy),
        .i_q_full      (w_q_full),
        .o_q_push      (w_q_push),
        .o_q_ctl       (w_q_ctl),
        .o_q_addr      (w_q_addr)
    );

    // op queue between the two ends
    mtc_fifo #(
        .WIDTH (Q_W),
        .DEPTH (Q_DEPTH)
    ) u_op_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  ({w_q_addr, w_q_ctl}),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_data  (w_q_rdata),
        .o_empty (w_q_empty)
    );

    // table engine
    mtc_back #(
        .MAX_STATES (MAX_STATES),
        .MAX_ORDER  (MAX_ORDER),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op_valid    (!w_q_empty),
        .i_op_ctl      (t_op_ctl'(w_q_rdata[CTL_W-1:0])),
        .i_op_addr     (w_q_rdata[Q_W-1:CTL_W]),
        .o_op_pop      (w_q_pop),
        .o_init_busy   (w_init_busy),
        .o_empty       (empty),
        .i_pop         (pop),
        .o_count_value (o_count_value)
    );

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for markov_transition_counter_core
// Drives directed and random command streams (symbols in sequences, table
// reads, clears) under several register settings, with random sender bursts
// and receiver stalls. A scoreboard class tracks the count tables and the
// context history and checks every read result in order.
// ----------------------------------------------------------------------------

// count tables, context history and the queue of read results still due
class markov_count_board;
    bit [3:0]  states_reg;
    bit [1:0]  order_reg;
    bit        from_start_reg;
    bit [2:0]  history [3];
    int unsigned seen_symbols;
    bit [31:0] trans_counts [512][8];
    bit [31:0] init_counts [8];
    bit [31:0] pending_counts [$];
    int unsigned failures;

    function new();
        states_reg     = mtc_pkg::SC_RESET;
        order_reg      = mtc_pkg::MO_RESET;
        from_start_reg = mtc_pkg::CFS_RESET;
        seen_symbols   = 0;
        failures       = 0;
    endfunction

    // state count clamped to the supported range
    function int unsigned active_states();
        int unsigned n;
        n = states_reg;
        if (n < 2) n = 2;
        if (n > 8) n = 8;
        return n;
    endfunction

    // order 0 acts as 1
    function int unsigned active_order();
        return (order_reg == 2'd0) ? 1 : order_reg;
    endfunction

    function int unsigned active_rows();
        int unsigned r;
        r = 1;
        repeat (active_order()) r *= active_states();
        return r;
    endfunction

    // row of the present context, most recent state weighted highest
    function int unsigned context_row();
        int unsigned n, r, w;
        n = active_states();
        r = 0;
        w = 1;
        for (int k = active_order(); k > 0; k--) begin
            r += history[k-1] * w;
            w *= n;
        end
        return r;
    endfunction

    function void set_register(mtc_pkg::t_cfg_idx idx, bit [3:0] data);
        case (idx)
            mtc_pkg::CFG_STATE_COUNT:      states_reg = data;
            mtc_pkg::CFG_MODEL_ORDER:      order_reg = data[1:0];
            mtc_pkg::CFG_COUNT_FROM_START: from_start_reg = data[0];
            default: ;
        endcase
    endfunction

    // update the tables for one accepted command, queue a read result
    function void note_command(mtc_pkg::t_cmd cmd, bit [2:0] sym, bit start,
                               bit [8:0] row, bit [2:0] col);
        int unsigned n, rows, ctx;
        n    = active_states();
        rows = active_rows();
        case (cmd)
            mtc_pkg::CMD_CLEAR: begin
                foreach (trans_counts[r, c]) trans_counts[r][c] = '0;
                foreach (init_counts[c]) init_counts[c] = '0;
            end
            mtc_pkg::CMD_SYMBOL: begin
                if (sym < n) begin
                    if (start) begin
                        if (init_counts[sym] != '1) init_counts[sym]++;
                        foreach (history[k]) history[k] = sym;
                        seen_symbols = 1;
                    end else begin
                        // stale context rows beyond the table in use are skipped
                        if (from_start_reg || seen_symbols >= active_order()) begin
                            ctx = context_row();
                            if (ctx < rows && trans_counts[ctx][sym] != '1)
                                trans_counts[ctx][sym]++;
                        end
                        history[2] = history[1];
                        history[1] = history[0];
                        history[0] = sym;
                        if (seen_symbols < 3) seen_symbols++;
                    end
                end
            end
            mtc_pkg::CMD_READ_TRANS:
                pending_counts.push_back((row < rows && col < n) ? trans_counts[row][col] : '0);
            default:
                pending_counts.push_back((col < n) ? init_counts[col] : '0);
        endcase
    endfunction

    function void check_count(bit [31:0] actual);
        bit [31:0] expected;
        if (pending_counts.size() == 0) begin
            $display("%0t: count %0d arrived with no read outstanding", $time, actual);
            failures++;
        end else begin
            expected = pending_counts.pop_front();
            if (actual !== expected) begin
                $display("%0t: count mismatch, expected %0d, actual %0d",
                         $time, expected, actual);
                failures++;
            end
        end
    endfunction

    function bit all_clean();
        if (pending_counts.size() != 0) begin
            $display("%0t: %0d reads never answered", $time, pending_counts.size());
            failures++;
        end
        return failures == 0;
    endfunction
endclass

module testbench;
    import mtc_pkg::*;

    localparam int STALL_LIMIT    = 40000;
    localparam int HOLD_CYCLES    = 400;
    localparam int PHASES         = 10;
    localparam int ITEMS_PER_HALF = 21;

    // register settings per random phase, extremes included
    int phase_states [PHASES] = '{8, 3, 2, 5, 0, 15, 4, 8, 7, 1};
    int phase_orders [PHASES] = '{3, 2, 1, 3, 0, 3, 2, 1, 2, 3};
    int phase_starts [PHASES] = '{1, 0, 0, 1, 1, 0, 1, 0, 0, 1};

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  push;
    logic                  full;
    logic [CMD_W-1:0]      i_cmd;
    logic [2:0]            i_state_value;
    logic                  i_seq_start;
    logic [8:0]            i_read_row;
    logic [2:0]            i_read_col;
    logic                  empty;
    logic                  pop;
    logic [31:0]           o_count_value;

    markov_count_board board = new();
    bit hold_request;
    bit gaps_on;
    int burst_left;

    markov_transition_counter_core #(
        .MAX_STATES (8),
        .MAX_ORDER  (3),
        .COUNT_BITS (32)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .push          (push),
        .full          (full),
        .i_cmd         (i_cmd),
        .i_state_value (i_state_value),
        .i_seq_start   (i_seq_start),
        .i_read_row    (i_read_row),
        .i_read_col    (i_read_col),
        .empty         (empty),
        .pop           (pop),
        .o_count_value (o_count_value)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // one command transfer; called and returns at a falling edge, push left high
    task automatic offer(t_cmd cmd, bit [2:0] sym, bit start, bit [8:0] row,
                         bit [2:0] col);
        push          <= 1'b1;
        i_cmd         <= cmd;
        i_state_value <= sym;
        i_seq_start   <= start;
        i_read_row    <= row;
        i_read_col    <= col;
        forever begin
            @(posedge i_clk);
            if (!full) break;
        end
        board.note_command(cmd, sym, start, row, col);
        @(negedge i_clk);
    endtask

    // stop sending until every read has been answered
    task automatic drain();
        push <= 1'b0;
        do @(negedge i_clk); while (board.pending_counts.size() != 0);
    endtask

    // trailing read flushes every earlier op (a clear too) out of the back end
    task automatic settle();
        offer(CMD_READ_INIT, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
              9'($urandom_range(0, 511)), 3'($urandom_range(0, 7)));
        drain();
        repeat (8) @(negedge i_clk);
    endtask

    task automatic configure(int states, int order, int from_start);
        t_cfg_idx idx;
        bit [3:0] data;
        for (int r = 0; r < 3; r++) begin
            idx  = t_cfg_idx'(r);
            data = (r == 0) ? 4'(states) : (r == 1) ? 4'(order) : 4'(from_start);
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idx;
            i_cfg_data <= data;
            @(negedge i_clk);
            board.set_register(idx, data);
        end
        i_cfg_we <= 1'b0;
    endtask

    // sender bursts with random gaps between them
    task automatic pace();
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, 6);
            if (gaps_on && gap != 0) begin
                push <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
    endtask

    // mostly well-formed sequences, reads aimed at the live context, some noise
    task automatic run_random(int count);
        int unsigned n, pick;
        bit [2:0] sym, col;
        bit [8:0] row;
        bit start;
        for (int i = 0; i < count; i++) begin
            pace();
            n     = board.active_states();
            pick  = $urandom_range(0, 99);
            sym   = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7))
                                               : 3'($urandom_range(0, n - 1));
            col   = 3'($urandom_range(0, 7));
            row   = 9'($urandom_range(0, 511));
            start = 1'($urandom_range(0, 1));
            if (pick < 50)
                offer(CMD_SYMBOL, sym, 1'b0, row, col);
            else if (pick < 58)
                offer(CMD_SYMBOL, sym, 1'b1, row, col);
            else if (pick < 73)
                offer(CMD_READ_TRANS, sym, start, 9'(board.context_row()),
                      3'($urandom_range(0, n - 1)));
            else if (pick < 83)
                offer(CMD_READ_TRANS, sym, start, row, col);
            else if (pick < 93)
                offer(CMD_READ_INIT, sym, start, row, col);
            else if (pick == 99 && $urandom_range(0, 2) == 0)
                offer(CMD_CLEAR, sym, start, row, col);
            else
                offer(t_cmd'(2'($urandom_range(1, 3))), 3'($urandom_range(0, 7)),
                      start, row, col);
        end
    endtask

    // result side: stall pattern of its own, long hold-off on request
    initial begin : receiver
        int mode, left;
        pop  = 1'b0;
        mode = 0;
        left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_request = 1'b0;
            end
            if (left == 0) begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(20, 80);
            end
            left--;
            case (mode)
                0: pop <= 1'b1;
                1: pop <= 1'($urandom_range(0, 1));
                2: pop <= ($urandom_range(0, 3) == 0);
                default: pop <= (left % 16 < 12);
            endcase
        end
    end

    // check every result transfer
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty)
            board.check_count(o_count_value);
    end

    // watchdog on cycles with no transfer on either side
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((push && !full) || (pop && !empty))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : stimulus
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_STATE_COUNT;
        i_cfg_data    = '0;
        push          = 1'b0;
        i_cmd         = CMD_CLEAR;
        i_state_value = '0;
        i_seq_start   = 1'b0;
        i_read_row    = '0;
        i_read_col    = '0;
        hold_request  = 1'b0;
        gaps_on       = 1'b0;
        burst_left    = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: empty tables, symbol before any sequence start
        offer(CMD_READ_INIT, 3'd0, 1'b0, 9'd0, 3'd0);
        offer(CMD_READ_TRANS, 3'd0, 1'b0, 9'd0, 3'd0);
        offer(CMD_SYMBOL, 3'd1, 1'b0, 9'd0, 3'd0);
        // a short sequence, out-of-range symbols ignored
        offer(CMD_SYMBOL, 3'd1, 1'b1, 9'd0, 3'd0);
        offer(CMD_SYMBOL, 3'd0, 1'b0, 9'd0, 3'd0);
        offer(CMD_SYMBOL, 3'd1, 1'b0, 9'd0, 3'd0);
        offer(CMD_SYMBOL, 3'd5, 1'b0, 9'd0, 3'd0);
        offer(CMD_SYMBOL, 3'd7, 1'b1, 9'd511, 3'd7);
        offer(CMD_READ_TRANS, 3'd0, 1'b0, 9'd1, 3'd0);
        offer(CMD_READ_TRANS, 3'd0, 1'b0, 9'd0, 3'd1);
        // reads outside the table in use, one initial count inside it
        offer(CMD_READ_TRANS, 3'd7, 1'b1, 9'd511, 3'd7);
        offer(CMD_READ_TRANS, 3'd0, 1'b0, 9'd2, 3'd0);
        offer(CMD_READ_INIT, 3'd0, 1'b0, 9'd0, 3'd1);
        offer(CMD_READ_INIT, 3'd0, 1'b0, 9'd0, 3'd7);
        // clear keeps the history
        offer(CMD_CLEAR, 3'd0, 1'b0, 9'd0, 3'd0);
        offer(CMD_READ_INIT, 3'd0, 1'b0, 9'd0, 3'd1);
        offer(CMD_READ_TRANS, 3'd0, 1'b0, 9'd0, 3'd1);

        // largest table, counting only after a full context
        settle();
        configure(8, 3, 0);
        offer(CMD_SYMBOL, 3'd3, 1'b1, 9'd0, 3'd0);
        offer(CMD_SYMBOL, 3'd2, 1'b0, 9'd0, 3'd0);
        offer(CMD_SYMBOL, 3'd5, 1'b0, 9'd0, 3'd0);
        offer(CMD_SYMBOL, 3'd6, 1'b0, 9'd0, 3'd0);
        offer(CMD_SYMBOL, 3'd7, 1'b0, 9'd0, 3'd0);
        offer(CMD_READ_TRANS, 3'd0, 1'b0, 9'd339, 3'd6);
        offer(CMD_READ_TRANS, 3'd0, 1'b0, 9'd426, 3'd7);

        // fewer states with a history written under more: stale context
        settle();
        configure(2, 1, 1);
        offer(CMD_SYMBOL, 3'd1, 1'b0, 9'd0, 3'd0);
        offer(CMD_SYMBOL, 3'd0, 1'b0, 9'd0, 3'd0);
        offer(CMD_READ_TRANS, 3'd0, 1'b0, 9'd1, 3'd0);

        // random phases over the register settings
        for (int p = 0; p < PHASES; p++) begin
            settle();
            configure(phase_states[p], phase_orders[p], phase_starts[p]);
            gaps_on    = (p % 3 != 0);
            burst_left = 0;
            if (p == 2) begin
                // receiver holds off while reads pile up until full rises
                hold_request = 1'b1;
                repeat (12)
                    offer(CMD_READ_INIT, 3'd0, 1'b0, 9'($urandom_range(0, 511)),
                          3'($urandom_range(0, 7)));
            end
            run_random(ITEMS_PER_HALF);
            if (p == 5) drain();
            run_random(ITEMS_PER_HALF);
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (board.all_clean())
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

### files.f
design/mtc_pkg.sv
design/mtc_fifo.sv
design/mtc_front.sv
design/mtc_back.sv
design/markov_transition_counter_core.sv
bench/testbench.sv
